>>> design/rpg_pkg.sv
// rpg_pkg: payload structs, command codes and controller interface types
// for the rounded polygon path generator; no dependencies
package rpg_pkg;

  localparam int CW = 24;
  localparam int RADIUS_W = 23;

  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_QUAD = 2'd1;
  localparam logic [1:0] CMD_LINE = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] vert_x;
    logic signed [CW-1:0] vert_y;
    logic                 vert_last;
  } vert_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [CW-1:0] ctrl_x;
    logic signed [CW-1:0] ctrl_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic                 path_done;
    logic                 run_last;
  } path_cmd_t;

  // edge endpoint selection
  typedef enum logic [1:0] {
    SEL_FIRST_SECOND = 2'd0,
    SEL_PREV_CUR     = 2'd1,
    SEL_CUR_FIRST    = 2'd2
  } edge_sel_t;

  typedef struct packed {
    logic      capture;   // latch input vertex
    logic      start;     // begin ratio computation
    edge_sel_t sel;
    logic      emit;      // load output register
    logic      emit_line; // line (else start point)
    logic      emit_move;
    logic      emit_done;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

endpackage

>>> design/rounded_polygon_path_gen_core.sv
// rounded_polygon_path_gen_core: top level of the rounded polygon path
// generator; depends on rpg_pkg, rpg_ctrl and rpg_datapath
//
// Vertices of a closed polygon enter on in_valid/in_ready, one per
// transaction, with vert_last on the final vertex. Path commands leave on
// out_valid/out_ready, up to seven per vertex, with run_last on the last
// one caused by that vertex and path_done on the closing quad.
// Each edge takes one ratio computation: two squarings, a bit-serial square
// root and a restoring divide, after which its commands are emitted as the
// receiver takes them.
// A vertex after the third costs one edge and the third costs two; a last
// vertex adds two more ratio computations for the closing edge and quad.
// The first two vertices of a polygon emit nothing.
// The user must write corner_radius through cfg_we/cfg_data only while
// idle; the block itself does not enforce it.
// Reset clears the vertex count, the radius and the output valid.
// A stalled receiver holds the output register; the sequencer waits and no
// new vertex is taken until the current one has finished.
module rounded_polygon_path_gen_core #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rpg_pkg::vert_t        in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rpg_pkg::path_cmd_t    out_data,
  input  logic                  cfg_we,
  input  logic [rpg_pkg::RADIUS_W-1:0] cfg_data
);
  logic [rpg_pkg::RADIUS_W-1:0] radius;
  rpg_pkg::dp_cmd_t  dcmd;
  rpg_pkg::dp_stat_t dstat;

  always_ff @(posedge clk) begin
    if (rst) radius <= '0;
    else if (cfg_we) radius <= cfg_data;
  end

  rpg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_last(in_data.vert_last),
    .out_valid, .out_ready, .cmdo(dcmd), .stat(dstat)
  );

  rpg_datapath #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_dp (
    .clk, .rst, .vin(in_data), .radius, .cmdi(dcmd), .stat(dstat), .res(out_data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("vertex taken with command pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.path_done |-> out_data.run_last)
    else $error("path_done without run_last");
endmodule

>>> design/rpg_datapath.sv
// rpg_datapath: vertex registers, iterative root and divide, interpolation
// and output register; depends on rpg_pkg
module rpg_datapath #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpg_pkg::vert_t           vin,
  input  logic [rpg_pkg::RADIUS_W-1:0] radius,
  input  rpg_pkg::dp_cmd_t         cmdi,
  output rpg_pkg::dp_stat_t        stat,
  output rpg_pkg::path_cmd_t       res
);
  localparam int COORD_WIDTH = rpg_pkg::CW;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int SQW = 2 * DW + 2;
  localparam int RTW = DW + 1;
  localparam int NW  = rpg_pkg::RADIUS_W + RATIO_FRAC_BITS + 1;
  localparam int RW  = RATIO_FRAC_BITS + 1;
  localparam int PW  = DW + RW + 1;
  localparam logic [RW-1:0] HALF = RW'(1) << (RATIO_FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SQ = 5'b00010, S_ROOT = 5'b00100,
    S_DIV = 5'b01000, S_FIN = 5'b10000
  } ph_t;

  logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [COORD_WIDTH-1:0] px, py, qx, qy;
  logic signed [DW-1:0] dx, dy;
  logic [SQW-1:0] rem, sq_acc;
  logic [RTW-1:0] root;
  logic [NW-1:0]  num, quo, drem;
  logic [7:0]     cnt;
  logic [RW-1:0]  ratio;
  ph_t ph;
  logic prod_phase;

  always_ff @(posedge clk) begin
    if (cmdi.capture) begin
      cur_x <= vin.vert_x;
      cur_y <= vin.vert_y;
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // first/second are written by the controller order: capture then shift
  logic cap_d;
  logic [1:0] slot;
  logic vin_last_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      cap_d <= 1'b0;
    end else begin
      cap_d <= cmdi.capture;
      if (cap_d) begin
        if (slot == 2'd0) begin
          first_x <= cur_x;
          first_y <= cur_y;
        end else if (slot == 2'd1) begin
          second_x <= cur_x;
          second_y <= cur_y;
        end
        if (vin_last_d) slot <= '0;
        else if (slot != 2'd2) slot <= slot + 2'd1;
      end
    end
  end
  always_ff @(posedge clk) if (cmdi.capture) vin_last_d <= vin.vert_last;

  always_comb begin
    case (cmdi.sel)
      rpg_pkg::SEL_FIRST_SECOND: begin
        px = first_x; py = first_y; qx = second_x; qy = second_y;
      end
      rpg_pkg::SEL_PREV_CUR: begin
        px = prev_x; py = prev_y; qx = cur_x; qy = cur_y;
      end
      default: begin
        px = cur_x; py = cur_y; qx = first_x; qy = first_y;
      end
    endcase
  end

  logic [DW-1:0] mx, my;
  assign mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign my = dy[DW-1] ? DW'(-dy) : DW'(dy);

  logic [SQW-1:0] trial;
  assign trial = SQW'({root, 2'b01}) ;
  logic [SQW-1:0] rem_sh;
  assign rem_sh = {rem[SQW-3:0], sq_acc[SQW-1 -: 2]};

  logic [NW:0] dtrial;
  assign dtrial = {1'b0, drem[NW-2:0], num[NW-1]} - {{(NW-RTW+1){1'b0}}, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= S_IDLE;
    end else begin
      case (ph)
        S_IDLE: if (cmdi.start) begin
          dx <= DW'(qx) - DW'(px);
          dy <= DW'(qy) - DW'(py);
          prod_phase <= 1'b0;
          ph <= S_SQ;
        end
        S_SQ: begin
          if (!prod_phase) begin
            sq_acc <= SQW'(mx * mx);
            prod_phase <= 1'b1;
          end else begin
            sq_acc <= sq_acc + SQW'(my * my);
            rem <= '0;
            root <= '0;
            cnt <= 8'(SQW / 2);
            ph <= S_ROOT;
          end
        end
        S_ROOT: begin
          sq_acc <= sq_acc << 2;
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            root <= {root[RTW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            root <= {root[RTW-2:0], 1'b0};
          end
          cnt <= cnt - 8'd1;
          if (cnt == 8'd1) ph <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 8'd0) begin
            num <= (NW'(radius) << RATIO_FRAC_BITS) + NW'(root >> 1);
            drem <= '0;
            quo <= '0;
            if (root == '0) begin
              cnt <= 8'(NW);
              ratio <= HALF;
              ph <= S_FIN;
            end else begin
              cnt <= 8'(NW) + 8'd1;
            end
          end else if (cnt == 8'd1) begin
            ratio <= (quo > NW'(HALF)) ? HALF : RW'(quo);
            ph <= S_FIN;
            cnt <= 8'd0;
          end else begin
            num <= num << 1;
            if (!dtrial[NW]) begin
              drem <= NW'(dtrial);
              quo <= {quo[NW-2:0], 1'b1};
            end else begin
              drem <= {drem[NW-2:0], num[NW-1]};
              quo <= {quo[NW-2:0], 1'b0};
            end
            cnt <= cnt - 8'd1;
          end
        end
        S_FIN: ph <= S_IDLE;
        default: ph <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (ph != S_IDLE) || cmdi.start;

  // interpolation: start = p + r*(q-p), end = q - r*(q-p)
  logic signed [PW-1:0] prx, pry, rrx, rry;
  assign prx = PW'(dx) * PW'($signed({1'b0, ratio}));
  assign pry = PW'(dy) * PW'($signed({1'b0, ratio}));
  assign rrx = -prx;
  assign rry = -pry;

  function automatic logic signed [COORD_WIDTH-1:0] rnd(
    input logic signed [COORD_WIDTH-1:0] base, input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + PW'(HALF);
    rnd = base + COORD_WIDTH'(t >>> RATIO_FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (cmdi.emit) begin
      res.path_done <= cmdi.emit_done;
      res.run_last  <= cmdi.emit_last;
      if (cmdi.emit_line) begin
        res.cmd <= rpg_pkg::CMD_LINE;
        res.ctrl_x <= '0; res.ctrl_y <= '0;
        res.end_x <= rnd(qx, rrx); res.end_y <= rnd(qy, rry);
      end else begin
        res.cmd <= cmdi.emit_move ? rpg_pkg::CMD_MOVE : rpg_pkg::CMD_QUAD;
        res.ctrl_x <= cmdi.emit_move ? '0 : px;
        res.ctrl_y <= cmdi.emit_move ? '0 : py;
        res.end_x <= rnd(px, prx); res.end_y <= rnd(py, pry);
      end
    end
  end
endmodule

>>> design/rpg_ctrl.sv
// rpg_ctrl: sequencer that walks the edges for each vertex and paces
// output transactions; depends on rpg_pkg
module rpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output rpg_pkg::dp_cmd_t   cmdo,
  input  rpg_pkg::dp_stat_t  stat
);
  typedef enum logic [5:0] {
    C_IDLE = 6'b000001, C_CALC = 6'b000010, C_WAIT = 6'b000100,
    C_S = 6'b001000, C_E = 6'b010000, C_OUT = 6'b100000
  } st_t;

  st_t st;
  logic [1:0] seen;
  logic last;
  logic [2:0] step;    // 0 first edge, 1 prev edge, 2 closing edge, 3 final quad
  logic out_full;

  assign in_ready = (st == C_IDLE) && !out_full;
  assign out_valid = out_full;

  function automatic logic [2:0] next_step(input logic [2:0] s, input logic l);
    if (s == 3'd0) next_step = 3'd1;
    else if (s == 3'd1) next_step = l ? 3'd2 : 3'd4;
    else if (s == 3'd2) next_step = 3'd3;
    else next_step = 3'd4;
  endfunction

  always_comb begin
    cmdo = '0;
    cmdo.capture = in_valid && in_ready;
    cmdo.sel = (step == 3'd1) ? rpg_pkg::SEL_PREV_CUR :
               (step == 3'd2) ? rpg_pkg::SEL_CUR_FIRST : rpg_pkg::SEL_FIRST_SECOND;
    cmdo.start = (st == C_CALC);
    if ((st == C_S || st == C_E) && !out_full) begin
      cmdo.emit = 1'b1;
      cmdo.emit_line = (st == C_E);
      cmdo.emit_move = (st == C_S) && (step == 3'd0);
      cmdo.emit_done = (st == C_S) && (step == 3'd3);
      cmdo.emit_last = ((st == C_E) && next_step(step, last) == 3'd4) ||
                       ((st == C_S) && step == 3'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_IDLE;
      seen <= '0;
      out_full <= 1'b0;
      step <= '0;
      last <= 1'b0;
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      if (cmdo.emit) out_full <= 1'b1;
      case (st)
        C_IDLE: if (in_valid && in_ready) begin
          last <= in_last;
          if (seen == 2'd0 || seen == 2'd1) begin
            seen <= in_last ? 2'd0 : seen + 2'd1;
          end else begin
            step <= (seen == 2'd2) ? 3'd0 : 3'd1;
            seen <= in_last ? 2'd0 : 2'd3;
            st <= C_WAIT;
          end
        end
        C_WAIT: st <= C_CALC;
        C_CALC: st <= C_OUT;
        C_OUT: if (!stat.busy) st <= C_S;
        C_S: if (!out_full) st <= (step == 3'd3) ? C_IDLE : C_E;
        C_E: if (!out_full) begin
          if (next_step(step, last) == 3'd4) st <= C_IDLE;
          else begin
            step <= next_step(step, last);
            st <= C_CALC;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end
endmodule

>>> bench/tb_rounded_polygon_path_gen_core.sv
// tb_rounded_polygon_path_gen_core: checks the rounded polygon path generator
// against a fixed-point predictor of the rounded-corner command stream;
// depends on rpg_pkg and rounded_polygon_path_gen_core
module tb_rounded_polygon_path_gen_core;

  class path_scoreboard;
    logic signed [rpg_pkg::CW-1:0] first_x, first_y, second_x, second_y, prev_x, prev_y;
    int unsigned seen;
    longint unsigned radius;
    rpg_pkg::path_cmd_t pending[$];
    int mismatches;
    int results_seen;
    int paths_closed;

    function new();
      seen = 0;
      radius = 0;
      mismatches = 0;
      results_seen = 0;
      paths_closed = 0;
      first_x = '0;
      first_y = '0;
      second_x = '0;
      second_y = '0;
      prev_x = '0;
      prev_y = '0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint unsigned ratio(longint px, longint py, longint qx, longint qy);
      longint dx, dy;
      longint unsigned mx, my, d, r, half;
      int s;
      dx = qx - px;
      dy = qy - py;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      half = 64'd1 << 15;
      s = 0;
      while ((mx >> 31) != 0 || (my >> 31) != 0) begin
        mx = mx >> 1;
        my = my >> 1;
        s++;
      end
      d = isqrt(mx * mx + my * my) << s;
      if (d == 0) return half;
      r = ((radius << 16) + (d >> 1)) / d;
      return r > half ? half : r;
    endfunction

    function longint lerp(longint a, longint b, longint unsigned r);
      longint t, q;
      t = (b - a) * longint'(r) + (64'sd1 <<< 15);
      if (t >= 0) q = t >>> 16;
      else q = -((-t + 65535) >>> 16);
      return a + q;
    endfunction

    function void put(logic [1:0] c, longint cx, longint cy, longint ex, longint ey,
                      bit done);
      rpg_pkg::path_cmd_t p;
      p.cmd = c;
      p.ctrl_x = cx[rpg_pkg::CW-1:0];
      p.ctrl_y = cy[rpg_pkg::CW-1:0];
      p.end_x = ex[rpg_pkg::CW-1:0];
      p.end_y = ey[rpg_pkg::CW-1:0];
      p.path_done = done;
      p.run_last = 1'b0;
      pending.push_back(p);
    endfunction

    function void corner_edge(bit is_move, longint px, longint py, longint qx,
                              longint qy);
      longint unsigned r;
      r = ratio(px, py, qx, qy);
      if (is_move) put(rpg_pkg::CMD_MOVE, 0, 0, lerp(px, qx, r), lerp(py, qy, r), 0);
      else put(rpg_pkg::CMD_QUAD, px, py, lerp(px, qx, r), lerp(py, qy, r), 0);
      put(rpg_pkg::CMD_LINE, 0, 0, lerp(qx, px, r), lerp(qy, py, r), 0);
    endfunction

    function void note_vertex(rpg_pkg::vert_t v);
      int before_n;
      longint unsigned r;
      before_n = pending.size();
      if (seen == 0) begin
        first_x = v.vert_x;
        first_y = v.vert_y;
        seen = 1;
      end else if (seen == 1) begin
        second_x = v.vert_x;
        second_y = v.vert_y;
        seen = 2;
      end else begin
        if (seen == 2) corner_edge(1, first_x, first_y, second_x, second_y);
        corner_edge(0, prev_x, prev_y, v.vert_x, v.vert_y);
        seen = 3;
      end
      prev_x = v.vert_x;
      prev_y = v.vert_y;
      if (v.vert_last) begin
        if (seen == 3) begin
          corner_edge(0, v.vert_x, v.vert_y, first_x, first_y);
          r = ratio(first_x, first_y, second_x, second_y);
          put(rpg_pkg::CMD_QUAD, first_x, first_y, lerp(first_x, second_x, r),
              lerp(first_y, second_y, r), 1);
        end
        seen = 0;
      end
      if (pending.size() > before_n) pending[pending.size()-1].run_last = 1'b1;
    endfunction

    function void check_cmd(rpg_pkg::path_cmd_t got);
      rpg_pkg::path_cmd_t want;
      results_seen++;
      if (got.path_done) paths_closed++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.cmd !== want.cmd || got.ctrl_x !== want.ctrl_x ||
          got.ctrl_y !== want.ctrl_y || got.end_x !== want.end_x ||
          got.end_y !== want.end_y || got.path_done !== want.path_done ||
          got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected cmd %0d ctrl %0d,%0d end %0d,%0d done %b last %b",
                   want.cmd, want.ctrl_x, want.ctrl_y, want.end_x, want.end_y,
                   want.path_done, want.run_last,
                   ", got cmd %0d ctrl %0d,%0d end %0d,%0d done %b last %b",
                   got.cmd, got.ctrl_x, got.ctrl_y,
                   got.end_x, got.end_y, got.path_done, got.run_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rpg_pkg::vert_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpg_pkg::path_cmd_t out_data;
  logic cfg_we = 1'b0;
  logic [rpg_pkg::RADIUS_W-1:0] cfg_data = '0;
  bit calm = 1'b0;
  int vertices_sent = 0;
  path_scoreboard sb;

  rounded_polygon_path_gen_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial sb = new();

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_cmd(out_data);
  end

  // receiver stalls in bursts
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // valid stays high after acceptance until the next call or drain drops it
  task automatic send_vertex(logic signed [rpg_pkg::CW-1:0] x,
                             logic signed [rpg_pkg::CW-1:0] y, bit lst);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_data <= '{vert_x: x, vert_y: y, vert_last: lst};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_vertex(in_data);
    vertices_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_radius(logic [rpg_pkg::RADIUS_W-1:0] r);
    cfg_data <= r;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.radius = r;
  endtask

  function automatic logic signed [rpg_pkg::CW-1:0] rand_coord(int unsigned span);
    if (span == 0) return rpg_pkg::CW'($urandom());
    return $signed(rpg_pkg::CW'($urandom_range(0, 2 * span))) - rpg_pkg::CW'(span);
  endfunction

  task automatic random_polygon(int unsigned span);
    int n;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 6);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(span), rand_coord(span), i == n - 1);
  endtask

  initial begin
    int spans[4];
    spans = '{256, 8192, 1000000, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_radius(23'd512);
    // square, then triangle with a zero-length edge and clamped ratio
    send_vertex(0, 0, 0);
    send_vertex(24'sd2560, 0, 0);
    send_vertex(24'sd2560, 24'sd2560, 0);
    send_vertex(0, 24'sd2560, 1);
    send_vertex(24'sd100, 24'sd100, 0);
    send_vertex(24'sd100, 24'sd100, 0);
    send_vertex(24'sd300, -24'sd50, 1);
    // short polygons
    send_vertex(24'sd7, 24'sd9, 1);
    send_vertex(24'sd1, 24'sd2, 0);
    send_vertex(-24'sd3, 24'sd4, 1);
    // coordinate extremes
    send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_vertex(24'sh800000, 24'sh800000, 0);
    send_vertex(24'sh7FFFFF, 24'sh800000, 0);
    send_vertex(24'sh800000, 24'sh7FFFFF, 1);
    drain();
    set_radius(23'h7FFFFF);
    send_vertex(24'sh800000, 0, 0);
    send_vertex(24'sh7FFFFF, 24'sd1, 0);
    send_vertex(0, 24'sh7FFFFF, 1);
    drain();
    set_radius(23'd0);
    send_vertex(24'sd10, 24'sd20, 0);
    send_vertex(-24'sd30, 24'sd40, 0);
    send_vertex(24'sd50, -24'sd60, 1);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      set_radius(phase == 3 ? 23'($urandom()) : 23'($urandom_range(0, 4096)));
      while (vertices_sent < 22 + (phase + 1) * 18)
        random_polygon(spans[phase]);
      drain();
    end
    calm = 1'b1;
    set_radius(23'd1024);
    while (vertices_sent < 110) random_polygon(8192);
    drain();
    $display("%0d vertices, %0d commands, %0d closed paths over several corner radii",
             vertices_sent, sb.results_seen, sb.paths_closed);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_rounded_polygon_path_gen_core passed");
    end else begin
      $display("%0d mismatches, %0d commands outstanding", sb.mismatches,
               sb.pending.size());
      $display("tb_rounded_polygon_path_gen_core failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("tb_rounded_polygon_path_gen_core failed");
    $finish;
  end
endmodule

>>> rounded_polygon_path_gen_core.f
design/rpg_pkg.sv
design/rpg_datapath.sv
design/rpg_ctrl.sv
design/rounded_polygon_path_gen_core.sv
bench/tb_rounded_polygon_path_gen_core.sv
